>>> design/jts_pkg.sv
// ----------------------------------------------------------------------------
// jts_pkg
// Types, character constants and the control program of the JSON token
// serializer.
// ----------------------------------------------------------------------------
package jts_pkg;

	// token codes
	typedef enum logic [3:0] {
		ACT_PROP      = 4'd0,
		ACT_STR_BYTE  = 4'd1,
		ACT_STR_END   = 4'd2,
		ACT_STR_BEGIN = 4'd3,
		ACT_RAW_BYTE  = 4'd4,
		ACT_RAW_END   = 4'd5,
		ACT_OPEN_OBJ  = 4'd6,
		ACT_OPEN_ARR  = 4'd7,
		ACT_CLOSE     = 4'd8,
		ACT_FINISH    = 4'd9
	} action_t;

	typedef enum logic [1:0] {
		POS_ROOT  = 2'd0,
		POS_FIRST = 2'd1,
		POS_ITEM  = 2'd2,
		POS_VALUE = 2'd3
	} pos_t;

	// conditions a control word can test
	typedef enum logic [3:0] {
		C_NEVER, C_ALWAYS, C_COMMA, C_KEY, C_NOKEY, C_INKEY, C_NOINKEY,
		C_ESC, C_NOESC, C_DEPTH0, C_DEPTH_NZ, C_DEPTH1, C_DEPTH_GT1, C_FULL
	} cond_t;
	localparam int COND_N = 14;

	typedef enum logic [2:0] {
		SRC_LIT, SRC_IN, SRC_ESC1, SRC_ESC2, SRC_CLOSE
	} src_t;

	typedef enum logic [2:0] {
		PO_KEEP, PO_FIRST, PO_ITEM, PO_VALUE, PO_POP, PO_STR
	} pos_op_t;

	typedef enum logic [1:0] {
		KO_KEEP, KO_CLEAR, KO_LOAD
	} key_op_t;

	typedef enum logic [1:0] {
		SO_NONE, SO_PUSH_OBJ, SO_PUSH_ARR, SO_POP
	} stk_op_t;

	typedef enum logic [1:0] {
		BR_NEXT, BR_END_IF, BR_JUMP_IF, BR_JUMP_ELSE_END
	} br_t;

	localparam int PC_W = 5;
	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		cond_t   emit_cond;
		src_t    src;
		logic [7:0] lit;
		cond_t   last_cond;
		logic    fail_out;
		logic    set_fail;
		pos_op_t pos_op;
		key_op_t key_op;
		stk_op_t stk_op;
		br_t     br;
		cond_t   br_cond;
		pc_t     target;
	} cw_t;

	typedef struct packed {
		logic run;
		cw_t  cw;
	} seq_ctl_t;

	typedef struct packed {
		logic hold;
		logic br_hit;
		logic failed;
	} dp_sts_t;

	// characters
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;

	// second byte of an escape, zero when the byte goes out as is
	function automatic logic [7:0] esc_code(input logic [7:0] c);
		logic [7:0] e;
		unique case (c)
			CH_BSLASH: e = CH_BSLASH;
			CH_QUOTE:  e = CH_QUOTE;
			CH_BS:     e = 8'h62;
			CH_FF:     e = 8'h66;
			CH_LF:     e = 8'h6E;
			CH_CR:     e = 8'h72;
			CH_TAB:    e = 8'h74;
			default:   e = 8'h00;
		endcase
		return e;
	endfunction

	// program addresses
	localparam pc_t PC_FAIL     = 5'd0;
	localparam pc_t PC_P_ROOT   = 5'd1;
	localparam pc_t PC_P_RCOMMA = 5'd2;
	localparam pc_t PC_P_OPEN   = 5'd3;
	localparam pc_t PC_P_COMMA  = 5'd4;
	localparam pc_t PC_P_KEY    = 5'd5;
	localparam pc_t PC_S_HEAD   = 5'd6;
	localparam pc_t PC_S_TAIL   = 5'd7;
	localparam pc_t PC_E_QUOTE  = 5'd8;
	localparam pc_t PC_E_COLON  = 5'd9;
	localparam pc_t PC_V_QUOTE  = 5'd10;
	localparam pc_t PC_RAW      = 5'd11;
	localparam pc_t PC_RAW_END  = 5'd12;
	localparam pc_t PC_OO_CHK   = 5'd13;
	localparam pc_t PC_OO_COMMA = 5'd14;
	localparam pc_t PC_OO_OPEN  = 5'd15;
	localparam pc_t PC_OA_CHK   = 5'd16;
	localparam pc_t PC_OA_COMMA = 5'd17;
	localparam pc_t PC_OA_OPEN  = 5'd18;
	localparam pc_t PC_CL_CHK   = 5'd19;
	localparam pc_t PC_CL_POP   = 5'd20;
	localparam pc_t PC_FN_CHK   = 5'd21;
	localparam pc_t PC_FN_POP   = 5'd22;

	localparam cw_t CW_NOP = '{
		emit_cond: C_NEVER, src: SRC_LIT, lit: 8'h00, last_cond: C_NEVER,
		fail_out: 1'b0, set_fail: 1'b0, pos_op: PO_KEEP, key_op: KO_KEEP,
		stk_op: SO_NONE, br: BR_NEXT, br_cond: C_NEVER, target: PC_FAIL
	};

	function automatic pc_t entry_pc(input logic [3:0] action);
		pc_t pc;
		unique case (action)
			ACT_PROP:      pc = PC_P_ROOT;
			ACT_STR_BYTE:  pc = PC_S_HEAD;
			ACT_STR_END:   pc = PC_E_QUOTE;
			ACT_STR_BEGIN: pc = PC_V_QUOTE;
			ACT_RAW_BYTE:  pc = PC_RAW;
			ACT_RAW_END:   pc = PC_RAW_END;
			ACT_OPEN_OBJ:  pc = PC_OO_CHK;
			ACT_OPEN_ARR:  pc = PC_OA_CHK;
			ACT_CLOSE:     pc = PC_CL_CHK;
			ACT_FINISH:    pc = PC_FN_CHK;
			default:       pc = PC_FAIL;
		endcase
		return pc;
	endfunction

	// control program
	function automatic cw_t rom(input pc_t pc);
		cw_t cw;
		cw = CW_NOP;
		unique case (pc)
			PC_FAIL: begin
				cw.emit_cond = C_ALWAYS;
				cw.last_cond = C_ALWAYS;
				cw.fail_out  = 1'b1;
				cw.set_fail  = 1'b1;
				cw.br        = BR_END_IF;
				cw.br_cond   = C_ALWAYS;
			end
			PC_P_ROOT: begin
				cw.br      = BR_JUMP_IF;
				cw.br_cond = C_DEPTH_NZ;
				cw.target  = PC_P_COMMA;
			end
			PC_P_RCOMMA: begin
				cw.emit_cond = C_COMMA;
				cw.lit       = CH_COMMA;
			end
			PC_P_OPEN: begin
				cw.emit_cond = C_ALWAYS;
				cw.lit       = CH_LBRACE;
				cw.last_cond = C_NOKEY;
				cw.stk_op    = SO_PUSH_OBJ;
				cw.pos_op    = PO_FIRST;
			end
			PC_P_COMMA: begin
				cw.emit_cond = C_COMMA;
				cw.lit       = CH_COMMA;
				cw.last_cond = C_NOKEY;
			end
			PC_P_KEY: begin
				cw.emit_cond = C_KEY;
				cw.lit       = CH_QUOTE;
				cw.last_cond = C_ALWAYS;
				cw.key_op    = KO_LOAD;
				cw.pos_op    = PO_VALUE;
				cw.br        = BR_END_IF;
				cw.br_cond   = C_ALWAYS;
			end
			PC_S_HEAD: begin
				cw.emit_cond = C_ALWAYS;
				cw.src       = SRC_ESC1;
				cw.last_cond = C_NOESC;
				cw.br        = BR_END_IF;
				cw.br_cond   = C_NOESC;
			end
			PC_S_TAIL: begin
				cw.emit_cond = C_ALWAYS;
				cw.src       = SRC_ESC2;
				cw.last_cond = C_ALWAYS;
				cw.br        = BR_END_IF;
				cw.br_cond   = C_ALWAYS;
			end
			PC_E_QUOTE: begin
				cw.emit_cond = C_ALWAYS;
				cw.lit       = CH_QUOTE;
				cw.last_cond = C_NOINKEY;
				cw.pos_op    = PO_STR;
				cw.br        = BR_END_IF;
				cw.br_cond   = C_NOINKEY;
			end
			PC_E_COLON: begin
				cw.emit_cond = C_ALWAYS;
				cw.lit       = CH_COLON;
				cw.last_cond = C_ALWAYS;
				cw.key_op    = KO_CLEAR;
				cw.br        = BR_END_IF;
				cw.br_cond   = C_ALWAYS;
			end
			PC_V_QUOTE: begin
				cw.emit_cond = C_ALWAYS;
				cw.lit       = CH_QUOTE;
				cw.last_cond = C_ALWAYS;
				cw.key_op    = KO_CLEAR;
				cw.br        = BR_END_IF;
				cw.br_cond   = C_ALWAYS;
			end
			PC_RAW: begin
				cw.emit_cond = C_ALWAYS;
				cw.src       = SRC_IN;
				cw.last_cond = C_ALWAYS;
				cw.br        = BR_END_IF;
				cw.br_cond   = C_ALWAYS;
			end
			PC_RAW_END: begin
				cw.pos_op  = PO_ITEM;
				cw.br      = BR_END_IF;
				cw.br_cond = C_ALWAYS;
			end
			PC_OO_CHK, PC_OA_CHK: begin
				cw.br      = BR_JUMP_IF;
				cw.br_cond = C_FULL;
				cw.target  = PC_FAIL;
			end
			PC_OO_COMMA, PC_OA_COMMA: begin
				cw.emit_cond = C_COMMA;
				cw.lit       = CH_COMMA;
			end
			PC_OO_OPEN: begin
				cw.emit_cond = C_ALWAYS;
				cw.lit       = CH_LBRACE;
				cw.last_cond = C_ALWAYS;
				cw.stk_op    = SO_PUSH_OBJ;
				cw.pos_op    = PO_FIRST;
				cw.br        = BR_END_IF;
				cw.br_cond   = C_ALWAYS;
			end
			PC_OA_OPEN: begin
				cw.emit_cond = C_ALWAYS;
				cw.lit       = CH_LBRACK;
				cw.last_cond = C_ALWAYS;
				cw.stk_op    = SO_PUSH_ARR;
				cw.pos_op    = PO_FIRST;
				cw.br        = BR_END_IF;
				cw.br_cond   = C_ALWAYS;
			end
			PC_CL_CHK: begin
				cw.br      = BR_JUMP_IF;
				cw.br_cond = C_DEPTH0;
				cw.target  = PC_FAIL;
			end
			PC_CL_POP: begin
				cw.emit_cond = C_ALWAYS;
				cw.src       = SRC_CLOSE;
				cw.last_cond = C_ALWAYS;
				cw.stk_op    = SO_POP;
				cw.pos_op    = PO_POP;
				cw.br        = BR_END_IF;
				cw.br_cond   = C_ALWAYS;
			end
			PC_FN_CHK: begin
				cw.br      = BR_END_IF;
				cw.br_cond = C_DEPTH0;
			end
			PC_FN_POP: begin
				cw.emit_cond = C_ALWAYS;
				cw.src       = SRC_CLOSE;
				cw.last_cond = C_DEPTH1;
				cw.stk_op    = SO_POP;
				cw.pos_op    = PO_POP;
				cw.br        = BR_JUMP_ELSE_END;
				cw.br_cond   = C_DEPTH_GT1;
				cw.target    = PC_FN_POP;
			end
			default: begin
				cw.br      = BR_END_IF;
				cw.br_cond = C_ALWAYS;
			end
		endcase
		return cw;
	endfunction

endpackage

>>> design/jts_if.sv
// ----------------------------------------------------------------------------
// jts_in_if / jts_out_if
// Token channel and text channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jts_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] action;
	logic [7:0] in_byte;
	logic       has_key;

	modport source (output valid, output action, output in_byte, output has_key,
		input ready);
	modport sink (input valid, input action, input in_byte, input has_key,
		output ready);
endinterface

interface jts_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic       failed;

	modport source (output valid, output out_byte, output last, output failed,
		input ready);
	modport sink (input valid, input out_byte, input last, input failed,
		output ready);
endinterface

>>> design/json_token_serializer.sv
// ----------------------------------------------------------------------------
// json_token_serializer
// Turns JSON writing tokens into output text, one byte per output word.
// ----------------------------------------------------------------------------
// Each token runs a short routine from a control store, one step per cycle
// while no step is held, with one output byte at most per step. Open and
// close tokens begin with a depth check step, a property that opens the root
// object first writes its opening brace, an escaped string byte writes a
// backslash and then its escape code, a key end writes the closing quote and
// then a colon, and finish writes one close byte per open level. A step that
// has a byte ready while the previous output word is still untaken is held
// until that word is taken. Unused token codes are taken and dropped without
// starting a routine. After a depth overflow or a close at root every token of
// a used code answers with a single failed word (byte 0, last set) until reset.
// ----------------------------------------------------------------------------
module json_token_serializer
	import jts_pkg::*;
#(
	parameter int MAX_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	jts_in_if.sink    tokens,
	jts_out_if.source text
);

	logic     accept;
	logic     ready;
	seq_ctl_t ctl;
	dp_sts_t  sts;

	assign tokens.ready = ready;
	assign accept       = tokens.valid && ready;

	jts_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.action (tokens.action),
		.sts    (sts),
		.ctl    (ctl),
		.ready  (ready)
	);

	jts_dp #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (tokens.in_byte),
		.has_key (tokens.has_key),
		.ctl     (ctl),
		.sts     (sts),
		.txt     (text)
	);

endmodule

>>> design/jts_seq.sv
// ----------------------------------------------------------------------------
// jts_seq
// Step counter and control store: dispatches a token to its routine and walks
// it one control word per cycle unless held, branching on datapath conditions.
// ----------------------------------------------------------------------------
module jts_seq
	import jts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [3:0] action,
	input  dp_sts_t    sts,
	output seq_ctl_t   ctl,
	output logic       ready
);

	logic busy_q, busy_d;
	pc_t  pc_q, pc_d;
	cw_t  cw;

	assign cw        = rom(pc_q);
	assign ctl.run   = busy_q;
	assign ctl.cw    = cw;
	assign ready     = !busy_q;

	always_comb begin
		busy_d = busy_q;
		pc_d   = pc_q;
		if (accept) begin
			// drop unused token codes without starting a routine
			if (action <= ACT_FINISH) begin
				busy_d = 1'b1;
				pc_d   = sts.failed ? PC_FAIL : entry_pc(action);
			end
		end else if (busy_q && !sts.hold) begin
			unique case (cw.br)
				BR_NEXT: pc_d = pc_q + pc_t'(1);
				BR_END_IF: begin
					if (sts.br_hit) busy_d = 1'b0;
					else pc_d = pc_q + pc_t'(1);
				end
				BR_JUMP_IF: pc_d = sts.br_hit ? cw.target : pc_q + pc_t'(1);
				BR_JUMP_ELSE_END: begin
					if (sts.br_hit) pc_d = cw.target;
					else busy_d = 1'b0;
				end
				default: busy_d = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= PC_FAIL;
		end else begin
			busy_q <= busy_d;
			pc_q   <= pc_d;
		end
	end

endmodule

>>> design/jts_dp.sv
// ----------------------------------------------------------------------------
// jts_dp
// Writer state (depth, kind stack, position, key flag, failure flag), token
// latch, condition flags for the control program and the output word register.
// ----------------------------------------------------------------------------
module jts_dp
	import jts_pkg::*;
#(
	parameter int MAX_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       has_key,
	input  seq_ctl_t   ctl,
	output dp_sts_t    sts,
	jts_out_if.source  txt
);

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	logic [DW-1:0]  depth_q;
	logic           kind_q [MAX_DEPTH];
	pos_t           pos_q;
	logic           in_key_q;
	logic           fail_q;
	logic [7:0]     byte_q;
	logic           key_q;

	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           out_last_q;
	logic           out_failed_q;

	logic [COND_N-1:0] cv;
	logic [7:0]     esc;
	logic [IW-1:0]  top_idx;
	logic [IW-1:0]  push_idx;
	logic [7:0]     sel_byte;
	logic           emit_now;
	logic           hold;
	logic           fire;
	cw_t            cw;

	assign cw       = ctl.cw;
	assign esc      = esc_code(byte_q);
	assign top_idx  = IW'(depth_q - DW'(1));
	assign push_idx = depth_q[IW-1:0];

	always_comb begin
		cv              = '0;
		cv[C_ALWAYS]    = 1'b1;
		cv[C_COMMA]     = (pos_q == POS_ITEM);
		cv[C_KEY]       = key_q;
		cv[C_NOKEY]     = !key_q;
		cv[C_INKEY]     = in_key_q;
		cv[C_NOINKEY]   = !in_key_q;
		cv[C_ESC]       = (esc != 8'h00);
		cv[C_NOESC]     = (esc == 8'h00);
		cv[C_DEPTH0]    = (depth_q == '0);
		cv[C_DEPTH_NZ]  = (depth_q != '0);
		cv[C_DEPTH1]    = (depth_q == DW'(1));
		cv[C_DEPTH_GT1] = (depth_q > DW'(1));
		cv[C_FULL]      = (depth_q >= DW'(MAX_DEPTH));
	end

	always_comb begin
		unique case (cw.src)
			SRC_LIT:   sel_byte = cw.lit;
			SRC_IN:    sel_byte = byte_q;
			SRC_ESC1:  sel_byte = cv[C_ESC] ? CH_BSLASH : byte_q;
			SRC_ESC2:  sel_byte = esc;
			SRC_CLOSE: sel_byte = kind_q[top_idx] ? CH_RBRACE : CH_RBRACK;
			default:   sel_byte = cw.lit;
		endcase
	end

	// hold an emitting step while the output word is still waiting
	assign emit_now = cv[cw.emit_cond];
	assign hold     = ctl.run && emit_now && out_valid_q && !txt.ready;
	assign fire     = ctl.run && !hold;

	assign sts.hold   = hold;
	assign sts.br_hit = cv[cw.br_cond];
	assign sts.failed = fail_q;

	assign txt.valid    = out_valid_q;
	assign txt.out_byte = out_byte_q;
	assign txt.last     = out_last_q;
	assign txt.failed   = out_failed_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= in_byte;
			key_q  <= has_key;
		end
		if (fire && emit_now) begin
			out_byte_q   <= sel_byte;
			out_last_q   <= cv[cw.last_cond];
			out_failed_q <= cw.fail_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			depth_q     <= '0;
			pos_q       <= POS_ROOT;
			in_key_q    <= 1'b0;
			fail_q      <= 1'b0;
			for (int i = 0; i < MAX_DEPTH; i++) kind_q[i] <= 1'b0;
		end else begin
			if (fire && emit_now) out_valid_q <= 1'b1;
			else if (txt.ready) out_valid_q <= 1'b0;

			if (fire) begin
				if (cw.set_fail) fail_q <= 1'b1;

				unique case (cw.pos_op)
					PO_KEEP:  pos_q <= pos_q;
					PO_FIRST: pos_q <= POS_FIRST;
					PO_ITEM:  pos_q <= POS_ITEM;
					PO_VALUE: pos_q <= POS_VALUE;
					PO_POP:   pos_q <= cv[C_DEPTH1] ? POS_ROOT : POS_ITEM;
					PO_STR:   pos_q <= in_key_q ? POS_VALUE : POS_ITEM;
					default:  pos_q <= pos_q;
				endcase

				unique case (cw.key_op)
					KO_KEEP:  in_key_q <= in_key_q;
					KO_CLEAR: in_key_q <= 1'b0;
					KO_LOAD:  in_key_q <= key_q;
					default:  in_key_q <= in_key_q;
				endcase

				unique case (cw.stk_op)
					SO_NONE: depth_q <= depth_q;
					SO_PUSH_OBJ: begin
						kind_q[push_idx] <= 1'b1;
						depth_q          <= depth_q + DW'(1);
					end
					SO_PUSH_ARR: begin
						kind_q[push_idx] <= 1'b0;
						depth_q          <= depth_q + DW'(1);
					end
					SO_POP:  depth_q <= depth_q - DW'(1);
					default: depth_q <= depth_q;
				endcase
			end
		end
	end

endmodule

>>> dv/tb_json_token_serializer.sv
// ----------------------------------------------------------------------------
// tb_json_token_serializer
// Self-checking testbench for the JSON token serializer. It sends a directed
// token run and then mostly well-formed random JSON token streams, and
// predicts the text bytes of every token. Each output word is checked against
// that prediction. Both channels idle at random in several phases, and the
// text side holds off once for long enough that the token side backs up. The
// run ends with the sticky failure state, entered either by a depth overflow
// or by a close at root.
// ----------------------------------------------------------------------------
module tb_json_token_serializer;
	import jts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 16;
	localparam int CHUNK_WORDS = 42;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN       = 60;

	typedef struct {
		logic [3:0] act;
		logic [7:0] ch;
		logic       key;
	} token_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		logic       failed;
	} text_word_t;

	logic clk = 1'b0;
	logic arst_n;

	jts_in_if  tok_if ();
	jts_out_if txt_if ();

	json_token_serializer #(.MAX_DEPTH(DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.tokens (tok_if),
		.text   (txt_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	token_t     token_q[$];
	text_word_t text_q[$];
	logic [7:0] step_bytes[$];

	int  err_cnt = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  tok_taken = 1'b0;
	bit  pressure_go = 1'b0;
	bit  hold_off = 1'b0;

	// writer state tracked by the predictor
	int              wr_depth;
	logic [DEPTH-1:0] wr_kinds;
	pos_t            wr_pos;
	logic            wr_in_key;
	logic            wr_failed;

	// nesting depth of the stream as generated, kept clear of failures
	int gen_depth = 0;
	int rand_items = 0;

	function automatic void put_comma();
		if (wr_pos == POS_ITEM)
			step_bytes.push_back(CH_COMMA);
	endfunction

	function automatic bit open_level(input bit obj);
		if (wr_depth >= DEPTH)
			return 1'b0;
		put_comma();
		step_bytes.push_back(obj ? CH_LBRACE : CH_LBRACK);
		wr_kinds[wr_depth] = obj;
		wr_depth++;
		wr_pos = POS_FIRST;
		return 1'b1;
	endfunction

	function automatic bit close_level();
		if (wr_depth == 0)
			return 1'b0;
		step_bytes.push_back(wr_kinds[wr_depth-1] ? CH_RBRACE : CH_RBRACK);
		wr_depth--;
		wr_pos = (wr_depth == 0) ? POS_ROOT : POS_ITEM;
		return 1'b1;
	endfunction

	task automatic predict_text(input token_t t);
		bit         ok;
		logic [7:0] esc;
		if (t.act > ACT_FINISH)
			return;
		ok = 1'b1;
		step_bytes.delete();
		if (!wr_failed) begin
			case (t.act)
				ACT_PROP: begin
					if (wr_depth == 0)
						ok = open_level(1'b1);
					if (ok) begin
						put_comma();
						if (t.key)
							step_bytes.push_back(CH_QUOTE);
						wr_in_key = t.key;
						wr_pos = POS_VALUE;
					end
				end
				ACT_STR_BYTE: begin
					case (t.ch)
						CH_BSLASH: esc = CH_BSLASH;
						CH_QUOTE:  esc = CH_QUOTE;
						CH_BS:     esc = "b";
						CH_FF:     esc = "f";
						CH_LF:     esc = "n";
						CH_CR:     esc = "r";
						CH_TAB:    esc = "t";
						default:   esc = 8'h00;
					endcase
					if (esc != 8'h00) begin
						step_bytes.push_back(CH_BSLASH);
						step_bytes.push_back(esc);
					end else begin
						step_bytes.push_back(t.ch);
					end
				end
				ACT_STR_END: begin
					step_bytes.push_back(CH_QUOTE);
					if (wr_in_key) begin
						step_bytes.push_back(CH_COLON);
						wr_pos = POS_VALUE;
					end else begin
						wr_pos = POS_ITEM;
					end
					wr_in_key = 1'b0;
				end
				ACT_STR_BEGIN: begin
					step_bytes.push_back(CH_QUOTE);
					wr_in_key = 1'b0;
				end
				ACT_RAW_BYTE: step_bytes.push_back(t.ch);
				ACT_RAW_END:  wr_pos = POS_ITEM;
				ACT_OPEN_OBJ: ok = open_level(1'b1);
				ACT_OPEN_ARR: ok = open_level(1'b0);
				ACT_CLOSE:    ok = close_level();
				default: begin
					while (wr_depth != 0)
						void'(close_level());
				end
			endcase
			if (!ok)
				wr_failed = 1'b1;
		end
		if (wr_failed) begin
			text_q.push_back('{ch: 8'h00, last: 1'b1, failed: 1'b1});
		end else begin
			foreach (step_bytes[i])
				text_q.push_back('{ch: step_bytes[i], last: (i == step_bytes.size() - 1),
					failed: 1'b0});
		end
	endtask

	// token side: hold the word until taken, then advance or idle
	always @(negedge clk) begin
		token_t tk;
		if (!tok_if.valid || tok_taken) begin
			if (token_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				tk = token_q.pop_front();
				tok_if.action  <= tk.act;
				tok_if.in_byte <= tk.ch;
				tok_if.has_key <= tk.key;
				tok_if.valid   <= 1'b1;
			end else begin
				tok_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		txt_if.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);

	// long hold on the text side so the token side backs up
	initial begin
		wait (pressure_go);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		text_word_t exp_w;
		tok_taken <= tok_if.valid && tok_if.ready;
		if (arst_n) begin
			if (tok_if.valid && tok_if.ready)
				predict_text('{act: tok_if.action, ch: tok_if.in_byte, key: tok_if.has_key});
			if (txt_if.valid && txt_if.ready) begin
				if (text_q.size() == 0) begin
					$error("unexpected word: out_byte %h last %b failed %b",
						txt_if.out_byte, txt_if.last, txt_if.failed);
					err_cnt++;
				end else begin
					exp_w = text_q.pop_front();
					if (txt_if.out_byte !== exp_w.ch) begin
						$error("out_byte: expected %h, got %h", exp_w.ch, txt_if.out_byte);
						err_cnt++;
					end
					if (txt_if.last !== exp_w.last) begin
						$error("last: expected %b, got %b", exp_w.last, txt_if.last);
						err_cnt++;
					end
					if (txt_if.failed !== exp_w.failed) begin
						$error("failed: expected %b, got %b", exp_w.failed, txt_if.failed);
						err_cnt++;
					end
				end
			end
		end
	end

	task automatic add_tok(input logic [3:0] a, input logic [7:0] c, input logic k);
		token_q.push_back('{act: a, ch: c, key: k});
		case (a)
			ACT_PROP:     if (gen_depth == 0) gen_depth = 1;
			ACT_OPEN_OBJ: gen_depth++;
			ACT_OPEN_ARR: gen_depth++;
			ACT_CLOSE:    if (gen_depth > 0) gen_depth--;
			ACT_FINISH:   gen_depth = 0;
			default: ;
		endcase
		if (a <= ACT_FINISH)
			rand_items++;
	endtask

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic rnd_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// string characters, biased toward the ones that need escaping
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0: return CH_BSLASH;
			1: return CH_QUOTE;
			2: return CH_BS;
			3: return CH_FF;
			4: return CH_LF;
			5: return CH_CR;
			6: return CH_TAB;
			default: return rnd_byte();
		endcase
	endfunction

	task automatic add_open();
		add_tok($urandom_range(0, 1) ? ACT_OPEN_OBJ : ACT_OPEN_ARR, rnd_byte(), rnd_bit());
	endtask

	task automatic add_str_body();
		repeat ($urandom_range(0, 5))
			add_tok(ACT_STR_BYTE, pick_char(), rnd_bit());
		add_tok(ACT_STR_END, rnd_byte(), rnd_bit());
	endtask

	task automatic add_value();
		case ($urandom_range(0, 3))
			0: begin
				add_tok(ACT_STR_BEGIN, rnd_byte(), rnd_bit());
				add_str_body();
			end
			1: begin
				repeat ($urandom_range(1, 4))
					add_tok(ACT_RAW_BYTE, 8'h30 + 8'($urandom_range(0, 9)), rnd_bit());
				add_tok(ACT_RAW_END, rnd_byte(), rnd_bit());
			end
			2: begin
				if (gen_depth < DEPTH)
					add_open();
				else
					add_tok(ACT_RAW_END, 8'h00, 1'b0);
			end
			default: begin
				repeat ($urandom_range(0, 3))
					add_tok(ACT_RAW_BYTE, rnd_byte(), rnd_bit());
				add_tok(ACT_RAW_END, rnd_byte(), rnd_bit());
			end
		endcase
	endtask

	// one piece of a JSON stream; never closes at root, never opens past the limit
	task automatic add_json_fragment();
		int         r;
		logic [3:0] a;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			a = {3'b000, ($urandom_range(0, 3) != 0)};
			add_tok(ACT_PROP, rnd_byte(), a[0]);
			if (a[0])
				add_str_body();
			add_value();
		end else if (r < 42) begin
			add_tok(ACT_PROP, rnd_byte(), 1'b0);
			add_value();
		end else if (r < 55) begin
			if (gen_depth < DEPTH)
				add_open();
			else
				add_tok(ACT_CLOSE, rnd_byte(), rnd_bit());
		end else if (r < 68) begin
			if (gen_depth > 0)
				add_tok(ACT_CLOSE, rnd_byte(), rnd_bit());
			else
				add_open();
		end else if (r < 73) begin
			add_tok(ACT_FINISH, rnd_byte(), rnd_bit());
		end else if (r < 85) begin
			a = 4'($urandom_range(0, 15));
			if (a == ACT_CLOSE && gen_depth == 0)
				a = ACT_RAW_BYTE;
			if ((a == ACT_OPEN_OBJ || a == ACT_OPEN_ARR) && gen_depth >= DEPTH)
				a = ACT_CLOSE;
			add_tok(a, rnd_byte(), rnd_bit());
		end else if (r < 90) begin
			// nest to the limit, then let finish unwind every level
			while (gen_depth < DEPTH) begin
				if ($urandom_range(0, 3) == 0) begin
					add_tok(ACT_PROP, rnd_byte(), 1'b1);
					add_str_body();
				end else begin
					add_open();
				end
			end
			add_tok(ACT_FINISH, rnd_byte(), rnd_bit());
		end else begin
			add_value();
		end
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
			2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
			3:       begin send_idle_pct = 19; recv_stall_pct = 19; end
			default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
		endcase
	endtask

	task automatic wait_sent();
		do
			@(posedge clk);
		while (token_q.size() != 0 || tok_if.valid);
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		tok_if.valid = 1'b0;
		tok_if.action = ACT_PROP;
		tok_if.in_byte = 8'h00;
		tok_if.has_key = 1'b0;
		txt_if.ready = 1'b0;
		wr_depth = 0;
		wr_kinds = '0;
		wr_pos = POS_ROOT;
		wr_in_key = 1'b0;
		wr_failed = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: root object, every escape, keys, raw values, nesting, unused codes
		set_idling(0);
		add_tok(ACT_PROP, 8'hFF, 1'b1);
		add_tok(ACT_STR_BYTE, 8'h00, 1'b0);
		add_tok(ACT_STR_BYTE, CH_BSLASH, 1'b1);
		add_tok(ACT_STR_BYTE, CH_QUOTE, 1'b0);
		add_tok(ACT_STR_BYTE, CH_BS, 1'b0);
		add_tok(ACT_STR_BYTE, CH_FF, 1'b0);
		add_tok(ACT_STR_BYTE, CH_LF, 1'b0);
		add_tok(ACT_STR_BYTE, CH_CR, 1'b0);
		add_tok(ACT_STR_BYTE, CH_TAB, 1'b0);
		add_tok(ACT_STR_BYTE, 8'hFF, 1'b1);
		add_tok(ACT_STR_END, 8'h00, 1'b0);
		add_tok(ACT_STR_BEGIN, 8'h00, 1'b1);
		add_tok(ACT_STR_BYTE, "x", 1'b0);
		add_tok(ACT_STR_END, 8'hFF, 1'b1);
		add_tok(ACT_PROP, 8'h00, 1'b0);
		add_tok(ACT_RAW_BYTE, 8'hFF, 1'b0);
		add_tok(ACT_RAW_BYTE, 8'h00, 1'b1);
		add_tok(ACT_RAW_END, 8'h00, 1'b0);
		add_tok(ACT_PROP, 8'h00, 1'b1);
		add_tok(ACT_STR_END, 8'h00, 1'b0);
		add_tok(ACT_OPEN_ARR, 8'h00, 1'b0);
		add_tok(ACT_OPEN_OBJ, 8'h00, 1'b0);
		add_tok(ACT_CLOSE, 8'h00, 1'b0);
		add_tok(4'd10, 8'hA5, 1'b1);
		add_tok(4'hF, 8'hFF, 1'b1);
		add_tok(ACT_FINISH, 8'h00, 1'b0);
		wait_sent();

		for (int ph = 0; ph < 8; ph++) begin
			set_idling(ph % 4);
			if (ph == 4)
				pressure_go = 1'b1;
			target = rand_items + CHUNK_WORDS;
			while (rand_items < target)
				add_json_fragment();
			wait_sent();
		end

		// enter the sticky failure state; each used token code then gets a failed word
		set_idling(3);
		if ($urandom_range(0, 1)) begin
			while (gen_depth < DEPTH)
				add_open();
			add_open();
		end else begin
			add_tok(ACT_FINISH, 8'h00, 1'b0);
			add_tok(ACT_CLOSE, 8'h00, 1'b0);
		end
		for (int a = 0; a <= 9; a++)
			add_tok(4'(a), rnd_byte(), rnd_bit());
		add_tok(4'd12, rnd_byte(), 1'b0);
		wait_sent();

		set_idling(0);
		while (text_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
design/jts_pkg.sv
design/jts_if.sv
design/jts_seq.sv
design/jts_dp.sv
design/json_token_serializer.sv
dv/tb_json_token_serializer.sv
